// ----- design/cckb_pkg.sv -----
// shared types, constants and codes for the clipped colour-key blitter
// no dependencies; used by cckb_clip, the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package cckb_pkg;

  // fixed field widths
  localparam int PIXEL_W    = 32;
  localparam int DIM_W      = 13;
  localparam int REG_W      = 7;
  localparam int COORD_W    = 6;
  localparam int CALC_W     = 16;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CNT_W      = 13;
  localparam int PROD_W     = 2 * DIM_W;
  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 64;

  // parameter defaults
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam logic [REG_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_SRC = 2'd0,
    FUNC_LOAD_DST = 2'd1,
    FUNC_READ_DST = 2'd2,
    FUNC_BLIT     = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST_W = 2'd0,
    CFG_DEST_H = 2'd1,
    CFG_SRC_W  = 2'd2,
    CFG_SRC_H  = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CLIP,
    ST_BASE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  // one clipped axis: size, destination and source position
  typedef struct packed {
    logic signed [CALC_W-1:0] sz;
    logic signed [CALC_W-1:0] to;
    logic signed [CALC_W-1:0] from;
  } clip_t;

  // result item, read_value in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]   drawn_count;
    logic [REG_W-1:0]   clip_h;
    logic [REG_W-1:0]   clip_w;
    logic [PIXEL_W-1:0] read_value;
  } result_t;

endpackage

`default_nettype wire

// ----- design/cckb_ram.sv -----
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module cckb_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/cckb_clip.sv -----
// clips one axis of a blit against the destination and source surfaces
// depends on cckb_pkg
`timescale 1ns / 1ps
`default_nettype none

module cckb_clip #(
  parameter int MAX_DIM = cckb_pkg::MAX_WIDTH_DEF
) (
  input  wire logic signed [cckb_pkg::DIM_W-1:0] size_i,
  input  wire logic signed [cckb_pkg::DIM_W-1:0] to_i,
  input  wire logic signed [cckb_pkg::DIM_W-1:0] from_i,
  input  wire logic        [cckb_pkg::REG_W-1:0] to_lim_i,
  input  wire logic        [cckb_pkg::REG_W-1:0] from_lim_i,
  output cckb_pkg::clip_t                        clip_o
);

  localparam logic [cckb_pkg::CALC_W-1:0] MaxDim = cckb_pkg::CALC_W'(MAX_DIM);

  logic [cckb_pkg::CALC_W-1:0]        to_lim_raw, from_lim_raw;
  logic signed [cckb_pkg::CALC_W-1:0] to_lim, from_lim;
  logic signed [cckb_pkg::CALC_W-1:0] sz1, to1, from1;
  logic signed [cckb_pkg::CALC_W-1:0] sz2, to2, from2;
  logic signed [cckb_pkg::CALC_W-1:0] room_to, room_from, room;

  always_comb begin
    // registers above the store act as the store size
    to_lim_raw   = cckb_pkg::CALC_W'(to_lim_i);
    from_lim_raw = cckb_pkg::CALC_W'(from_lim_i);
    to_lim       = $signed((to_lim_raw > MaxDim) ? MaxDim : to_lim_raw);
    from_lim     = $signed((from_lim_raw > MaxDim) ? MaxDim : from_lim_raw);

    // negative source offset
    sz1   = cckb_pkg::CALC_W'(size_i);
    to1   = cckb_pkg::CALC_W'(to_i);
    from1 = cckb_pkg::CALC_W'(from_i);
    if (from1 < 0) begin
      sz1   = sz1 + from1;
      to1   = to1 - from1;
      from1 = '0;
    end

    // negative destination offset
    sz2   = sz1;
    to2   = to1;
    from2 = from1;
    if (to2 < 0) begin
      sz2   = sz2 + to2;
      from2 = from2 - to2;
      to2   = '0;
    end

    room_to   = to_lim - to2;
    room_from = from_lim - from2;
    room      = (room_to < room_from) ? room_to : room_from;

    clip_o.sz   = (sz2 < room) ? sz2 : room;
    clip_o.to   = to2;
    clip_o.from = from2;
  end

endmodule

`default_nettype wire

// ----- design/clipped_color_key_blitter.sv -----
// top level of the clipped colour-key blitter: control sequencer, blit walker,
// surface memories and result queue; depends on cckb_pkg, cckb_ram, cckb_clip
//
// usage
//   s_axis carries one item per handshake: tuser holds the function code,
//   tdata the load/read coordinates, the pixel, the blit geometry and the key.
//   m_axis returns exactly one result item per input item, in order.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the surface sizes; write them only
//   while the block is idle.
// sequencing
//   load source / load destination: result pushed in the cycle the item is taken
//   read destination: synchronous memory read, then result pushed from read state
//   blit: clip state pushes an all-zero result when clipping leaves nothing, else
//   base, run and drain follow; the walker reads one source pixel per cycle and
//   writes the destination in the cycle after, so the memory port sets the rate
// stalls and reset
//   results go into a two-entry queue, so an item is taken while one result
//   still waits; the input stalls only when both entries are full or a
//   read or blit is in flight. reset empties the queue, returns the
//   sequencer to idle and sets every surface size to 64; surface contents
//   are undefined until written and get no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module clipped_color_key_blitter #(
  parameter int MAX_WIDTH  = cckb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cckb_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,

  // pixel_x, pixel_y, pixel_value, to_x, to_y, from_x, from_y, blit_w,
  // blit_h, key_enable, key_color, zero fill
  input  wire logic [cckb_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // func
  input  wire logic [cckb_pkg::FUNC_W-1:0]           s_axis_tuser,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,

  // read_value, clip_w, clip_h, drawn_count, zero fill
  output logic [cckb_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,

  input  wire logic                                  cfg_we_i,
  input  wire logic [cckb_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [cckb_pkg::REG_W-1:0]            cfg_data_i
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  localparam int PW = cckb_pkg::PIXEL_W;
  localparam int DW = cckb_pkg::DIM_W;
  localparam int RW = cckb_pkg::REG_W;
  localparam int CW = cckb_pkg::CNT_W;
  localparam int QW = cckb_pkg::PROD_W;

  // ---------------------------------------------------------------------
  // input field decode
  // ---------------------------------------------------------------------
  cckb_pkg::func_e          in_func;
  logic [cckb_pkg::COORD_W-1:0] in_px, in_py;
  logic [PW-1:0]            in_pixel, in_key;
  logic signed [DW-1:0]     in_tx, in_ty, in_fx, in_fy, in_bw, in_bh;
  logic                     in_key_en;

  assign in_func   = cckb_pkg::func_e'(s_axis_tuser);
  assign in_px     = s_axis_tdata[5:0];
  assign in_py     = s_axis_tdata[11:6];
  assign in_pixel  = s_axis_tdata[43:12];
  assign in_tx     = s_axis_tdata[56:44];
  assign in_ty     = s_axis_tdata[69:57];
  assign in_fx     = s_axis_tdata[82:70];
  assign in_fy     = s_axis_tdata[95:83];
  assign in_bw     = s_axis_tdata[108:96];
  assign in_bh     = s_axis_tdata[121:109];
  assign in_key_en = s_axis_tdata[122];
  assign in_key    = s_axis_tdata[154:123];

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // load / read address, only used when the pixel is inside the store
  logic          in_inside;
  logic [AW-1:0] pix_addr;

  assign in_inside = (DW'(in_px) < DW'(MAX_WIDTH)) && (DW'(in_py) < DW'(MAX_HEIGHT));
  assign pix_addr  = AW'(QW'(in_py) * QW'(MAX_WIDTH) + QW'(in_px));

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [RW-1:0] dest_w_q, dest_h_q, src_w_q, src_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_w_q <= cckb_pkg::DIM_RESET;
      dest_h_q <= cckb_pkg::DIM_RESET;
      src_w_q  <= cckb_pkg::DIM_RESET;
      src_h_q  <= cckb_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cckb_pkg::cfg_e'(cfg_idx_i))
        cckb_pkg::CFG_DEST_W: dest_w_q <= cfg_data_i;
        cckb_pkg::CFG_DEST_H: dest_h_q <= cfg_data_i;
        cckb_pkg::CFG_SRC_W:  src_w_q  <= cfg_data_i;
        cckb_pkg::CFG_SRC_H:  src_h_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // latched request
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] req_tx_q, req_ty_q, req_fx_q, req_fy_q, req_bw_q, req_bh_q;
  logic                 key_en_q;
  logic [PW-1:0]        key_q;
  logic                 rd_inside_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_tx_q    <= in_tx;
      req_ty_q    <= in_ty;
      req_fx_q    <= in_fx;
      req_fy_q    <= in_fy;
      req_bw_q    <= in_bw;
      req_bh_q    <= in_bh;
      key_en_q    <= in_key_en;
      key_q       <= in_key;
      rd_inside_q <= in_inside;
    end
  end

  // clipping of both axes, evaluated in the clip state
  cckb_pkg::clip_t clip_x, clip_y;

  cckb_clip #(
    .MAX_DIM (MAX_WIDTH)
  ) u_clip_x (
    .size_i     (req_bw_q),
    .to_i       (req_tx_q),
    .from_i     (req_fx_q),
    .to_lim_i   (dest_w_q),
    .from_lim_i (src_w_q),
    .clip_o     (clip_x)
  );

  cckb_clip #(
    .MAX_DIM (MAX_HEIGHT)
  ) u_clip_y (
    .size_i     (req_bh_q),
    .to_i       (req_ty_q),
    .from_i     (req_fy_q),
    .to_lim_i   (dest_h_q),
    .from_lim_i (src_h_q),
    .clip_o     (clip_y)
  );

  // ---------------------------------------------------------------------
  // surface memories
  // ---------------------------------------------------------------------
  logic          src_we, src_re;
  logic [AW-1:0] src_raddr;
  logic [PW-1:0] src_rdata;
  logic          dst_we, dst_re;
  logic [AW-1:0] dst_waddr;
  logic [PW-1:0] dst_wdata, dst_rdata;

  cckb_ram #(
    .DEPTH (Depth),
    .AW    (AW),
    .DW    (PW)
  ) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (pix_addr),
    .wdata_i (in_pixel),
    .re_i    (src_re),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

  cckb_ram #(
    .DEPTH (Depth),
    .AW    (AW),
    .DW    (PW)
  ) u_dst_ram (
    .clk_i   (clk_i),
    .we_i    (dst_we),
    .waddr_i (dst_waddr),
    .wdata_i (dst_wdata),
    .re_i    (dst_re),
    .raddr_i (pix_addr),
    .rdata_o (dst_rdata)
  );

  // ---------------------------------------------------------------------
  // blit walker state
  // ---------------------------------------------------------------------
  cckb_pkg::state_e state_q, state_d;

  logic [DW-1:0] w_q, w_d, h_q, h_d;
  logic [DW-1:0] tx_q, tx_d, ty_q, ty_d, fx_q, fx_d, fy_q, fy_d;
  logic [DW-1:0] x_q, x_d, y_q, y_d;
  logic [AW-1:0] src_row_q, src_row_d, dst_row_q, dst_row_d;
  logic [CW-1:0] cnt_q, cnt_d, cnt_inc;
  logic          pv_q, pv_d;        // source read in flight
  logic [AW-1:0] pdaddr_q, pdaddr_d;

  // pixel write stage: source data has arrived, write unless keyed out
  logic pix_wr;
  assign pix_wr  = pv_q && !(key_en_q && (src_rdata == key_q));
  assign cnt_inc = (pix_wr && (cnt_q != '1)) ? cnt_q + CW'(1) : cnt_q;

  assign src_we    = accept && (in_func == cckb_pkg::FUNC_LOAD_SRC) && in_inside;
  assign src_re    = (state_q == cckb_pkg::ST_RUN);
  assign src_raddr = src_row_q + AW'(x_q);

  // load and read only happen while idle, blit writes never overlap them
  assign dst_we    = (accept && (in_func == cckb_pkg::FUNC_LOAD_DST) && in_inside) || pix_wr;
  assign dst_waddr = pix_wr ? pdaddr_q : pix_addr;
  assign dst_wdata = pix_wr ? src_rdata : in_pixel;
  assign dst_re    = accept && (in_func == cckb_pkg::FUNC_READ_DST);

  // result queue interface
  logic              push;
  cckb_pkg::result_t push_data;
  logic [1:0]        q_cnt_q;

  assign s_axis_tready = (state_q == cckb_pkg::ST_IDLE) && (q_cnt_q != 2'd2);

  always_comb begin
    state_d   = state_q;
    w_d       = w_q;
    h_d       = h_q;
    tx_d      = tx_q;
    ty_d      = ty_q;
    fx_d      = fx_q;
    fy_d      = fy_q;
    x_d       = x_q;
    y_d       = y_q;
    src_row_d = src_row_q;
    dst_row_d = dst_row_q;
    cnt_d     = cnt_inc;
    pv_d      = 1'b0;
    pdaddr_d  = pdaddr_q;
    push      = 1'b0;
    push_data = '0;

    unique case (state_q)
      cckb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            cckb_pkg::FUNC_LOAD_SRC,
            cckb_pkg::FUNC_LOAD_DST: push = 1'b1;
            cckb_pkg::FUNC_READ_DST: state_d = cckb_pkg::ST_READ;
            cckb_pkg::FUNC_BLIT:     state_d = cckb_pkg::ST_CLIP;
            default: ;
          endcase
        end
      end

      cckb_pkg::ST_READ: begin
        push                 = 1'b1;
        push_data.read_value = rd_inside_q ? dst_rdata : '0;
        state_d              = cckb_pkg::ST_IDLE;
      end

      cckb_pkg::ST_CLIP: begin
        if ((clip_x.sz > 0) && (clip_y.sz > 0)) begin
          w_d     = DW'(clip_x.sz);
          h_d     = DW'(clip_y.sz);
          tx_d    = DW'(clip_x.to);
          fx_d    = DW'(clip_x.from);
          ty_d    = DW'(clip_y.to);
          fy_d    = DW'(clip_y.from);
          state_d = cckb_pkg::ST_BASE;
        end else begin
          // nothing left to draw: all-zero result
          push    = 1'b1;
          state_d = cckb_pkg::ST_IDLE;
        end
      end

      cckb_pkg::ST_BASE: begin
        src_row_d = AW'(QW'(fy_q) * QW'(MAX_WIDTH) + QW'(fx_q));
        dst_row_d = AW'(QW'(ty_q) * QW'(MAX_WIDTH) + QW'(tx_q));
        x_d       = '0;
        y_d       = '0;
        cnt_d     = '0;
        state_d   = cckb_pkg::ST_RUN;
      end

      cckb_pkg::ST_RUN: begin
        pv_d     = 1'b1;
        pdaddr_d = dst_row_q + AW'(x_q);
        if (x_q == w_q - DW'(1)) begin
          x_d       = '0;
          src_row_d = src_row_q + AW'(MAX_WIDTH);
          dst_row_d = dst_row_q + AW'(MAX_WIDTH);
          if (y_q == h_q - DW'(1)) begin
            state_d = cckb_pkg::ST_DRAIN;
          end else begin
            y_d = y_q + DW'(1);
          end
        end else begin
          x_d = x_q + DW'(1);
        end
      end

      cckb_pkg::ST_DRAIN: begin
        // last pixel is written this cycle
        push                  = 1'b1;
        push_data.clip_w      = (w_q > DW'(127)) ? '1 : w_q[RW-1:0];
        push_data.clip_h      = (h_q > DW'(127)) ? '1 : h_q[RW-1:0];
        push_data.drawn_count = cnt_inc;
        state_d               = cckb_pkg::ST_IDLE;
      end

      default: state_d = cckb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cckb_pkg::ST_IDLE;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= w_d;
    h_q       <= h_d;
    tx_q      <= tx_d;
    ty_q      <= ty_d;
    fx_q      <= fx_d;
    fy_q      <= fy_d;
    x_q       <= x_d;
    y_q       <= y_d;
    src_row_q <= src_row_d;
    dst_row_q <= dst_row_d;
    cnt_q     <= cnt_d;
    pdaddr_q  <= pdaddr_d;
  end

  // ---------------------------------------------------------------------
  // two-entry result queue, head drives the output channel
  // ---------------------------------------------------------------------
  cckb_pkg::result_t q_head_q, q_tail_q;
  logic              pop, slot;

  assign pop  = m_axis_tvalid && m_axis_tready;
  assign slot = (q_cnt_q == 2'd2) || ((q_cnt_q == 2'd1) && !pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= 2'd0;
    end else begin
      q_cnt_q <= q_cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    // a push into a free head wins over the shift from the tail
    if (push && !slot) begin
      q_head_q <= push_data;
    end else if (pop) begin
      q_head_q <= q_tail_q;
    end
    if (push && slot) begin
      q_tail_q <= push_data;
    end
  end

  assign m_axis_tvalid = (q_cnt_q != 2'd0);
  assign m_axis_tdata  = cckb_pkg::OUT_TDATA_W'(q_head_q);

endmodule

`default_nettype wire

// ----- sim/tb_clipped_color_key_blitter.sv -----
// self-checking testbench for the clipped colour-key blitter: a queue-fed stream driver,
// a receiver with random and long stalls, and an in-order checker against a behavioural
// predictor of both pixel surfaces; depends on cckb_pkg and clipped_color_key_blitter
`timescale 1ns / 1ps

module tb_clipped_color_key_blitter;

  localparam int PIXEL_W     = cckb_pkg::PIXEL_W;
  localparam int COORD_W     = cckb_pkg::COORD_W;
  localparam int DIM_W       = cckb_pkg::DIM_W;
  localparam int REG_W       = cckb_pkg::REG_W;
  localparam int CNT_W       = cckb_pkg::CNT_W;
  localparam int FUNC_W      = cckb_pkg::FUNC_W;
  localparam int CFG_IDX_W   = cckb_pkg::CFG_IDX_W;
  localparam int IN_TDATA_W  = cckb_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = cckb_pkg::OUT_TDATA_W;

  localparam int MAX_W        = cckb_pkg::MAX_WIDTH_DEF;
  localparam int MAX_H        = cckb_pkg::MAX_HEIGHT_DEF;
  localparam int SURF_WORDS   = MAX_W * MAX_H;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 235;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [PIXEL_W-1:0] KEY_GREEN = 32'h00FF00FF;

  // one input item, fields at the block's widths
  typedef struct {
    cckb_pkg::func_e           op;
    logic [COORD_W-1:0]        px;
    logic [COORD_W-1:0]        py;
    logic [PIXEL_W-1:0]        pix;
    logic signed [DIM_W-1:0]   tx;
    logic signed [DIM_W-1:0]   ty;
    logic signed [DIM_W-1:0]   fx;
    logic signed [DIM_W-1:0]   fy;
    logic signed [DIM_W-1:0]   bw;
    logic signed [DIM_W-1:0]   bh;
    logic                      key_on;
    logic [PIXEL_W-1:0]        key;
  } pix_req_t;

  // blit rectangle after clipping
  typedef struct {
    int w, h, tx, ty, fx, fy;
  } span_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [FUNC_W-1:0]      s_axis_tuser  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [REG_W-1:0]       cfg_data_i    = '0;

  // predictor state: both surfaces and the surface sizes in use
  logic [PIXEL_W-1:0] src_px [SURF_WORDS];
  logic [PIXEL_W-1:0] dst_px [SURF_WORDS];
  int                 surf_dim [4];

  // stimulus bookkeeping: which words are known to hold a written pixel
  bit  src_ok [SURF_WORDS];
  bit  dst_ok [SURF_WORDS];
  int  dst_list [$];

  pix_req_t          queued_requests [$];
  cckb_pkg::result_t pending_results [$];
  pix_req_t          cur_req;
  int                staged_count   = 0;
  int                mismatch_total = 0;

  // idle percentages per side and the long receiver hold-off handshake
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  bit in_taken      = 1'b0;

  clipped_color_key_blitter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // clipping, shared by the predictor and the stimulus generator
  // ---------------------------------------------------------------------------

  // a negative source offset shrinks the size and pushes the destination on,
  // a negative destination offset does the same to the source; then clamp
  function automatic void clip_span(inout int sz, inout int to, inout int from,
                                    input int to_lim, input int from_lim);
    if (from < 0) begin
      sz += from;
      to -= from;
      from = 0;
    end
    if (to < 0) begin
      sz += to;
      from -= to;
      to = 0;
    end
    if (to_lim - to < sz) sz = to_lim - to;
    if (from_lim - from < sz) sz = from_lim - from;
  endfunction

  function automatic span_t clip_blit(pix_req_t r);
    span_t s;
    int    dw, dh, sw, sh;
    // a size register above the store acts as the store size
    dw = (surf_dim[cckb_pkg::CFG_DEST_W] > MAX_W) ? MAX_W : surf_dim[cckb_pkg::CFG_DEST_W];
    dh = (surf_dim[cckb_pkg::CFG_DEST_H] > MAX_H) ? MAX_H : surf_dim[cckb_pkg::CFG_DEST_H];
    sw = (surf_dim[cckb_pkg::CFG_SRC_W] > MAX_W) ? MAX_W : surf_dim[cckb_pkg::CFG_SRC_W];
    sh = (surf_dim[cckb_pkg::CFG_SRC_H] > MAX_H) ? MAX_H : surf_dim[cckb_pkg::CFG_SRC_H];
    s.w  = int'(r.bw);
    s.h  = int'(r.bh);
    s.tx = int'(r.tx);
    s.ty = int'(r.ty);
    s.fx = int'(r.fx);
    s.fy = int'(r.fy);
    clip_span(s.w, s.tx, s.fx, dw, sw);
    clip_span(s.h, s.ty, s.fy, dh, sh);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: applies one accepted item to the surfaces, returns its result
  // ---------------------------------------------------------------------------
  function automatic cckb_pkg::result_t blit_engine_step(pix_req_t r);
    cckb_pkg::result_t  res;
    span_t              s;
    int                 drawn;
    int                 sa;
    int                 pa;
    bit                 in_store;
    logic [PIXEL_W-1:0] p;
    res = '0;
    // loads outside the store are dropped, reads there return zero
    in_store = (int'(r.px) < MAX_W) && (int'(r.py) < MAX_H);
    pa = int'(r.py) * MAX_W + int'(r.px);
    case (r.op)
      cckb_pkg::FUNC_LOAD_SRC: if (in_store) src_px[pa] = r.pix;
      cckb_pkg::FUNC_LOAD_DST: if (in_store) dst_px[pa] = r.pix;
      cckb_pkg::FUNC_READ_DST: if (in_store) res.read_value = dst_px[pa];
      default: begin
        s = clip_blit(r);
        drawn = 0;
        // an empty clipped size draws nothing and reports all zeros
        if (s.w > 0 && s.h > 0) begin
          for (int y = 0; y < s.h; y++) begin
            for (int x = 0; x < s.w; x++) begin
              sa = (s.fy + y) * MAX_W + s.fx + x;
              p  = src_px[sa];
              // keyed pixels leave the destination untouched
              if (!r.key_on || p != r.key) begin
                dst_px[(s.ty + y) * MAX_W + s.tx + x] = p;
                drawn++;
              end
            end
          end
          // counts saturate at the field widths
          res.clip_w      = REG_W'((s.w > 127) ? 127 : s.w);
          res.clip_h      = REG_W'((s.h > 127) ? 127 : s.h);
          res.drawn_count = CNT_W'((drawn > 8191) ? 8191 : drawn);
        end
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  // pixels often come from a small palette so that keying really hits
  function automatic logic [PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return KEY_GREEN;
      3: return 32'h12345678;
      default: return $urandom;
    endcase
  endfunction

  // every field random, so bits a function ignores still toggle
  function automatic pix_req_t rand_fields(cckb_pkg::func_e op);
    pix_req_t r;
    r.op     = op;
    r.px     = COORD_W'($urandom);
    r.py     = COORD_W'($urandom);
    r.pix    = rand_pixel();
    r.tx     = DIM_W'($urandom);
    r.ty     = DIM_W'($urandom);
    r.fx     = DIM_W'($urandom);
    r.fy     = DIM_W'($urandom);
    r.bw     = DIM_W'($urandom);
    r.bh     = DIM_W'($urandom);
    r.key_on = 1'($urandom);
    r.key    = rand_pixel();
    return r;
  endfunction

  function automatic pix_req_t pixel_req(cckb_pkg::func_e op, int x, int y,
                                         logic [PIXEL_W-1:0] v);
    pix_req_t r;
    r     = rand_fields(op);
    r.px  = COORD_W'(x);
    r.py  = COORD_W'(y);
    r.pix = v;
    return r;
  endfunction

  function automatic pix_req_t blit_req(int tx, int ty, int fx, int fy, int w, int h,
                                        logic key_on, logic [PIXEL_W-1:0] key);
    pix_req_t r;
    r        = rand_fields(cckb_pkg::FUNC_BLIT);
    r.tx     = DIM_W'(tx);
    r.ty     = DIM_W'(ty);
    r.fx     = DIM_W'(fx);
    r.fy     = DIM_W'(fy);
    r.bw     = DIM_W'(w);
    r.bh     = DIM_W'(h);
    r.key_on = key_on;
    r.key    = key;
    return r;
  endfunction

  // stage an item and note which words it leaves written; keyed blits are
  // not counted since skipped pixels keep whatever was there
  function automatic void queue_req(pix_req_t r);
    span_t s;
    int    a;
    queued_requests.push_back(r);
    staged_count++;
    a = int'(r.py) * MAX_W + int'(r.px);
    if (r.op == cckb_pkg::FUNC_LOAD_SRC) src_ok[a] = 1'b1;
    if (r.op == cckb_pkg::FUNC_LOAD_DST && !dst_ok[a]) begin
      dst_ok[a] = 1'b1;
      dst_list.push_back(a);
    end
    if (r.op == cckb_pkg::FUNC_BLIT && !r.key_on) begin
      s = clip_blit(r);
      for (int y = 0; y < s.h; y++) begin
        for (int x = 0; x < s.w; x++) begin
          a = (s.ty + y) * MAX_W + s.tx + x;
          if (!dst_ok[a]) begin
            dst_ok[a] = 1'b1;
            dst_list.push_back(a);
          end
        end
      end
    end
  endfunction

  // a blit preceded by loads of any source word it would read unwritten;
  // refused when that takes more than fill_cap loads
  function automatic bit add_blit(pix_req_t r, int fill_cap);
    span_t s;
    int    missing [$];
    int    a;
    s = clip_blit(r);
    for (int y = 0; y < s.h; y++) begin
      for (int x = 0; x < s.w; x++) begin
        a = (s.fy + y) * MAX_W + s.fx + x;
        if (!src_ok[a]) missing.push_back(a);
      end
    end
    if (missing.size() > fill_cap) return 1'b0;
    foreach (missing[i])
      queue_req(pixel_req(cckb_pkg::FUNC_LOAD_SRC, missing[i] % MAX_W, missing[i] / MAX_W,
                          rand_pixel()));
    queue_req(r);
    return 1'b1;
  endfunction

  // random mix: mostly loads, reads of written pixels and small blits near
  // the surfaces, some long rows or columns and a few blits of pure noise
  function automatic void fill_random(int count);
    pix_req_t r;
    int       start;
    int       pick;
    int       cap;
    bit       ok;
    start = staged_count;
    while (staged_count - start < count) begin
      pick = $urandom_range(19);
      if (pick < 5) begin
        queue_req(pixel_req(cckb_pkg::FUNC_LOAD_SRC, $urandom_range(63), $urandom_range(63),
                            rand_pixel()));
      end else if (pick < 8 || (pick < 11 && dst_list.size() == 0)) begin
        queue_req(rand_fields(cckb_pkg::FUNC_LOAD_DST));
      end else if (pick < 11) begin
        r = pixel_req(cckb_pkg::FUNC_READ_DST, 0, 0, $urandom);
        pick = dst_list[$urandom_range(dst_list.size() - 1)];
        r.px = COORD_W'(pick % MAX_W);
        r.py = COORD_W'(pick / MAX_W);
        queue_req(r);
      end else begin
        ok = 1'b0;
        for (int tries = 0; tries < 10 && !ok; tries++) begin
          r = rand_fields(cckb_pkg::FUNC_BLIT);
          if (pick < 18) begin
            // small rectangle around the surfaces, edges and corners
            r.tx = DIM_W'(int'($urandom_range(70)) - 4);
            r.ty = DIM_W'(int'($urandom_range(70)) - 4);
            r.fx = DIM_W'(int'($urandom_range(70)) - 4);
            r.fy = DIM_W'(int'($urandom_range(70)) - 4);
            r.bw = DIM_W'(int'($urandom_range(10)) - 2);
            r.bh = DIM_W'(int'($urandom_range(10)) - 2);
            cap = 24;
          end else if (pick == 18) begin
            // a whole row or column, clamped by the surface width or height
            r.tx = DIM_W'(int'($urandom_range(16)) - 8);
            r.ty = DIM_W'(int'($urandom_range(16)) - 8);
            r.fx = DIM_W'(int'($urandom_range(16)) - 8);
            r.fy = DIM_W'(int'($urandom_range(16)) - 8);
            r.bw = DIM_W'($urandom_range(100, 40));
            r.bh = DIM_W'($urandom_range(2, 1));
            if ($urandom_range(1)) begin
              r.bh = r.bw;
              r.bw = DIM_W'($urandom_range(2, 1));
            end
            cap = 140;
          end else begin
            cap = 8;
          end
          ok = add_blit(r, cap);
        end
        if (!ok)
          queue_req(pixel_req(cckb_pkg::FUNC_LOAD_SRC, $urandom_range(63), $urandom_range(63),
                              rand_pixel()));
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: next item at the falling edge once the last one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = queued_requests.pop_front();
        s_axis_tdata <= IN_TDATA_W'({cur_req.key, cur_req.key_on, cur_req.bh, cur_req.bw,
                                     cur_req.fy, cur_req.fx, cur_req.ty, cur_req.tx,
                                     cur_req.pix, cur_req.py, cur_req.px});
        s_axis_tuser  <= cur_req.op;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off when the sequence asks for
  // one, so the result queue fills and the block stops taking items
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_seen != hold_asks) begin
      hold_seen     <= hold_asks;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each accepted item, check each accepted result
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatch_total++;
    end
  endfunction

  always @(posedge clk_i) begin
    cckb_pkg::result_t exp_res;
    cckb_pkg::result_t got_res;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) pending_results.push_back(blit_engine_step(cur_req));
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("result item with none expected: %0h", m_axis_tdata);
          mismatch_total++;
        end else begin
          exp_res = pending_results.pop_front();
          got_res = cckb_pkg::result_t'(m_axis_tdata[$bits(cckb_pkg::result_t)-1:0]);
          check_field("read_value", exp_res.read_value, got_res.read_value);
          check_field("clip_w", exp_res.clip_w, got_res.clip_w);
          check_field("clip_h", exp_res.clip_h, got_res.clip_h);
          check_field("drawn_count", exp_res.drawn_count, got_res.drawn_count);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  // block idle: nothing staged, nothing on the bus, no result outstanding
  task automatic wait_idle();
    while (queued_requests.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dim(cckb_pkg::cfg_e idx, int v);
    @(negedge clk_i);
    cfg_we_i      = 1'b1;
    cfg_idx_i     = idx;
    cfg_data_i    = REG_W'(v);
    surf_dim[idx] = v;
    @(negedge clk_i);
    cfg_we_i      = 1'b0;
  endtask

  initial begin
    // surface sizes per phase: reset values, smallest, mixed, largest, mixed, random
    int dim_plan [PHASES][4] = '{'{64, 64, 64, 64}, '{1, 1, 1, 1}, '{37, 9, 64, 23},
                                 '{64, 64, 64, 64}, '{5, 64, 64, 2}, '{0, 0, 0, 0}};
    // idle per phase: none, sender, receiver, both, none, sender
    int send_plan [PHASES] = '{0, 56, 0, 26, 0, 56};
    int recv_plan [PHASES] = '{0, 0, 56, 26, 0, 0};

    foreach (surf_dim[i]) surf_dim[i] = int'(cckb_pkg::DIM_RESET);
    foreach (src_px[i]) begin
      src_px[i] = '0;
      dst_px[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        wait_idle();
        for (int k = 0; k < 4; k++)
          write_dim(cckb_pkg::cfg_e'(k),
                    (ph == PHASES - 1) ? $urandom_range(64, 1) : dim_plan[ph][k]);
      end
      send_idle_pct = send_plan[ph];
      recv_idle_pct = recv_plan[ph];

      if (ph == 0) begin
        // directed: extreme pixels and corners, loads then read-back
        queue_req(pixel_req(cckb_pkg::FUNC_LOAD_SRC, 0, 0, '1));
        queue_req(pixel_req(cckb_pkg::FUNC_LOAD_SRC, 1, 0, KEY_GREEN));
        queue_req(pixel_req(cckb_pkg::FUNC_LOAD_SRC, 0, 1, 32'h12345678));
        queue_req(pixel_req(cckb_pkg::FUNC_LOAD_SRC, 1, 1, KEY_GREEN));
        queue_req(pixel_req(cckb_pkg::FUNC_LOAD_SRC, 63, 63, '0));
        queue_req(pixel_req(cckb_pkg::FUNC_LOAD_DST, 0, 0, 32'hA5A5A5A5));
        queue_req(pixel_req(cckb_pkg::FUNC_LOAD_DST, 63, 63, '1));
        queue_req(pixel_req(cckb_pkg::FUNC_READ_DST, 0, 0, '0));
        queue_req(pixel_req(cckb_pkg::FUNC_READ_DST, 63, 63, '0));
        // plain copy, read back, then keyed copies that skip two pixels and one pixel
        void'(add_blit(blit_req(10, 10, 0, 0, 2, 2, 1'b0, KEY_GREEN), SURF_WORDS));
        queue_req(pixel_req(cckb_pkg::FUNC_READ_DST, 10, 10, '0));
        void'(add_blit(blit_req(12, 10, 0, 0, 2, 2, 1'b1, KEY_GREEN), SURF_WORDS));
        void'(add_blit(blit_req(30, 30, 0, 0, 2, 2, 1'b1, '1), SURF_WORDS));
        // empty sizes: zero width, most negative height, start past the surface, source offset past the size
        void'(add_blit(blit_req(5, 5, 0, 0, 0, 5, 1'b0, '0), SURF_WORDS));
        void'(add_blit(blit_req(5, 5, 0, 0, 3, -4096, 1'b0, '0), SURF_WORDS));
        void'(add_blit(blit_req(4095, 0, 0, 0, 4095, 4095, 1'b0, '0), SURF_WORDS));
        void'(add_blit(blit_req(0, 0, -4096, -4096, 4095, 4095, 1'b0, '0), SURF_WORDS));
        // negative source offset, then negative destination offset
        void'(add_blit(blit_req(20, 20, -1, -1, 3, 3, 1'b0, '0), SURF_WORDS));
        void'(add_blit(blit_req(-1, -1, 0, 0, 3, 3, 1'b1, KEY_GREEN), SURF_WORDS));
        // clamped by the destination edge, then by the source edge
        void'(add_blit(blit_req(63, 63, 0, 0, 5, 5, 1'b0, '0), SURF_WORDS));
        void'(add_blit(blit_req(0, 30, 63, 63, 5, 5, 1'b0, '0), SURF_WORDS));
      end

      fill_random(PHASE_ITEMS / 2);
      // sender pauses here until every result so far has come back
      if (ph == 1) wait_idle();
      fill_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      // long receiver hold-off while the sender keeps offering items
      if (ph == 2) hold_asks++;
    end

    wait_idle();
    if (mismatch_total == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
